// ===== src/psds_pkg.sv =====
// shared types and constants for the parity split double stack
package psds_pkg;

    localparam int DATA_W    = 32;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int DEPTH_F_W = 5;

    // request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH     = 2'd0,
        CMD_POP_LOW  = 2'd1,
        CMD_POP_HIGH = 2'd2,
        CMD_PEEK     = 2'd3
    } t_command;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    // controller to datapath commands
    typedef struct packed {
        logic take;
        logic load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic need_read;
    } t_dp_stat;

endpackage

// ===== src/psds_if.sv =====
// request and result channel interfaces
interface psds_req_if;
    logic                              valid;
    logic                              ready;
    logic [psds_pkg::CMD_W-1:0]        command;
    logic signed [psds_pkg::DATA_W-1:0] push_value;

    modport source (output valid, output command, output push_value, input ready);
    modport sink (input valid, input command, input push_value, output ready);
endinterface

interface psds_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [psds_pkg::STATUS_W-1:0]        status;
    logic signed [psds_pkg::DATA_W-1:0]   popped_value;
    logic signed [psds_pkg::DATA_W-1:0]   low_top;
    logic                                 low_nonempty;
    logic signed [psds_pkg::DATA_W-1:0]   high_top;
    logic                                 high_nonempty;
    logic [psds_pkg::DEPTH_F_W-1:0]       low_depth;
    logic [psds_pkg::DEPTH_F_W-1:0]       high_depth;

    modport source (output valid, output status, output popped_value, output low_top,
                    output low_nonempty, output high_top, output high_nonempty,
                    output low_depth, output high_depth, input ready);
    modport sink (input valid, input status, input popped_value, input low_top,
                  input low_nonempty, input high_top, input high_nonempty,
                  input low_depth, input high_depth, output ready);
endinterface

// ===== src/psds_ctrl.sv =====
// controller: sequences accept, top reload and result handoff
module psds_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    output logic                o_rsp_valid,
    input  logic                i_rsp_ready,
    input  psds_pkg::t_dp_stat  i_stat,
    output psds_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_RESP
    } t_state;

    t_state r_state;
    logic   r_ready;
    logic   r_valid;
    logic   take;

    assign take        = i_req_valid && r_ready;
    assign o_req_ready = r_ready;
    assign o_rsp_valid = r_valid;
    assign o_cmd.take  = take;
    assign o_cmd.load  = (r_state == S_LOAD);

    // state and registered handshake outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_ready <= 1'b0;
                        if (i_stat.need_read) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_state <= S_RESP;
                            r_valid <= 1'b1;
                        end
                    end
                end
                S_LOAD: begin
                    r_state <= S_RESP;
                    r_valid <= 1'b1;
                end
                S_RESP: begin
                    if (i_rsp_ready) begin
                        r_state <= S_IDLE;
                        r_valid <= 1'b0;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_ready <= 1'b1;
                    r_valid <= 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== src/psds_dp.sv =====
// datapath: shared store, stack counts, cached tops and result fields
module psds_dp #(
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  psds_pkg::t_dp_cmd                     i_cmd,
    output psds_pkg::t_dp_stat                    o_stat,
    input  logic [psds_pkg::CMD_W-1:0]            i_command,
    input  logic signed [psds_pkg::DATA_W-1:0]    i_push_value,
    output logic [psds_pkg::STATUS_W-1:0]         o_status,
    output logic signed [psds_pkg::DATA_W-1:0]    o_popped_value,
    output logic signed [psds_pkg::DATA_W-1:0]    o_low_top,
    output logic                                  o_low_nonempty,
    output logic signed [psds_pkg::DATA_W-1:0]    o_high_top,
    output logic                                  o_high_nonempty,
    output logic [psds_pkg::DEPTH_F_W-1:0]        o_low_depth,
    output logic [psds_pkg::DEPTH_F_W-1:0]        o_high_depth
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [psds_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [psds_pkg::DATA_W-1:0] r_rd_data;
    logic [CW-1:0]               r_low_cnt;
    logic [CW-1:0]               r_high_cnt;
    logic [psds_pkg::DATA_W-1:0] r_low_top;
    logic [psds_pkg::DATA_W-1:0] r_high_top;
    logic [psds_pkg::DATA_W-1:0] r_popped;
    psds_pkg::t_status           r_status;
    logic                        r_load_high;

    psds_pkg::t_command          cmd;
    logic                        full;
    logic                        low_empty;
    logic                        high_empty;
    logic                        low_multi;
    logic                        high_multi;
    logic                        wr_en;
    logic [CW-1:0]               wr_addr_w;
    logic [CW-1:0]               rd_addr_w;

    assign cmd        = psds_pkg::t_command'(i_command);
    assign full       = ({1'b0, r_low_cnt} + {1'b0, r_high_cnt}) >= (CW+1)'(DEPTH);
    assign low_empty  = (r_low_cnt == '0);
    assign high_empty = (r_high_cnt == '0);
    assign low_multi  = (r_low_cnt > CW'(1));
    assign high_multi = (r_high_cnt > CW'(1));

    // a pop that leaves entries behind reloads the new top from the store
    always_comb begin
        o_stat.need_read = 1'b0;
        rd_addr_w        = r_low_cnt - CW'(2);
        case (cmd)
            psds_pkg::CMD_POP_LOW: begin
                o_stat.need_read = low_multi;
                rd_addr_w        = r_low_cnt - CW'(2);
            end
            psds_pkg::CMD_POP_HIGH: begin
                o_stat.need_read = high_multi;
                rd_addr_w        = CW'(DEPTH) - r_high_cnt + CW'(1);
            end
            default: begin
                o_stat.need_read = 1'b0;
            end
        endcase
    end

    // push write address by parity
    always_comb begin
        wr_en     = i_cmd.take && (cmd == psds_pkg::CMD_PUSH) && !full;
        wr_addr_w = i_push_value[0] ? (CW'(DEPTH - 1) - r_high_cnt) : r_low_cnt;
    end

    // shared store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr_w[AW-1:0]] <= i_push_value;
        end
        if (i_cmd.take && o_stat.need_read) begin
            r_rd_data <= r_mem[rd_addr_w[AW-1:0]];
        end
    end

    // stack counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_cnt  <= '0;
            r_high_cnt <= '0;
        end else if (i_cmd.take) begin
            case (cmd)
                psds_pkg::CMD_PUSH: begin
                    if (!full) begin
                        if (i_push_value[0]) begin
                            r_high_cnt <= r_high_cnt + CW'(1);
                        end else begin
                            r_low_cnt <= r_low_cnt + CW'(1);
                        end
                    end
                end
                psds_pkg::CMD_POP_LOW: begin
                    if (!low_empty) begin
                        r_low_cnt <= r_low_cnt - CW'(1);
                    end
                end
                psds_pkg::CMD_POP_HIGH: begin
                    if (!high_empty) begin
                        r_high_cnt <= r_high_cnt - CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // cached tops, result status and popped value
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_status    <= psds_pkg::STATUS_OK;
            r_popped    <= '0;
            r_load_high <= (cmd == psds_pkg::CMD_POP_HIGH);
            case (cmd)
                psds_pkg::CMD_PUSH: begin
                    if (full) begin
                        r_status <= psds_pkg::STATUS_FULL;
                    end else if (i_push_value[0]) begin
                        r_high_top <= i_push_value;
                    end else begin
                        r_low_top <= i_push_value;
                    end
                end
                psds_pkg::CMD_POP_LOW: begin
                    if (low_empty) begin
                        r_status <= psds_pkg::STATUS_EMPTY;
                    end else begin
                        r_popped <= r_low_top;
                    end
                end
                psds_pkg::CMD_POP_HIGH: begin
                    if (high_empty) begin
                        r_status <= psds_pkg::STATUS_EMPTY;
                    end else begin
                        r_popped <= r_high_top;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd.load) begin
            if (r_load_high) begin
                r_high_top <= r_rd_data;
            end else begin
                r_low_top <= r_rd_data;
            end
        end
    end

    // result fields, empty tops read as zero
    assign o_status        = r_status;
    assign o_popped_value  = r_popped;
    assign o_low_nonempty  = !low_empty;
    assign o_high_nonempty = !high_empty;
    assign o_low_top       = low_empty ? '0 : r_low_top;
    assign o_high_top      = high_empty ? '0 : r_high_top;
    assign o_low_depth     = psds_pkg::DEPTH_F_W'(r_low_cnt);
    assign o_high_depth    = psds_pkg::DEPTH_F_W'(r_high_cnt);

endmodule

// ===== src/parity_split_double_stack.sv =====
// two stacks in one store, steered by the parity of the pushed value
// Usage:
//   i_req carries one request: command (push, pop low, pop high, peek) and
//   push_value. Even values go to the low stack (grows up from entry 0),
//   odd values to the high stack (grows down from entry DEPTH-1).
//   o_rsp returns exactly one result per request: status, popped value,
//   both tops with non-empty flags and both depths after the request.
// Timing:
//   Requests are handled one at a time. A push, peek, refused request or a
//   pop that empties its stack shows its result in the cycle after acceptance;
//   a pop that leaves entries behind first passes through a load state for the
//   registered read of the new top from the single store read port.
//   A new request is taken only after the previous result has been handed off.
// Reset:
//   Synchronous active-low reset empties both stacks; store contents are
//   not cleared and are never read before being written.
// Stall:
//   While the receiver holds ready low the result stays on o_rsp and no new
//   request is taken.
module parity_split_double_stack #(
    parameter int DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    psds_req_if.sink     i_req,
    psds_rsp_if.source   o_rsp
);

    psds_pkg::t_dp_cmd  cmd;
    psds_pkg::t_dp_stat stat;

    psds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    psds_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_command       (i_req.command),
        .i_push_value    (i_req.push_value),
        .o_status        (o_rsp.status),
        .o_popped_value  (o_rsp.popped_value),
        .o_low_top       (o_rsp.low_top),
        .o_low_nonempty  (o_rsp.low_nonempty),
        .o_high_top      (o_rsp.high_top),
        .o_high_nonempty (o_rsp.high_nonempty),
        .o_low_depth     (o_rsp.low_depth),
        .o_high_depth    (o_rsp.high_depth)
    );

endmodule
